// File: rtl/tcs_pkg.sv
// Shared types and constants for the text console scroll buffer.
`default_nettype none
package tcs_pkg;

	localparam int SCREEN_ROWS = 16;
	localparam int SCREEN_COLS = 64;

	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int COL_W  = $clog2(SCREEN_COLS);
	localparam int LEN_W  = $clog2(SCREEN_COLS + 1);
	localparam int ADDR_W = ROW_W + COL_W;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_NULL      = 8'd0;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] char_code;
		logic [3:0] row;
		logic [5:0] column;
	} in_item_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [3:0] current_row;
		logic [6:0] line_length;
		logic       scrolled;
	} out_item_t;

	// One classified operation handed from the front to the back.
	typedef struct packed {
		logic              wr_en;
		logic              rd_hit;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
		logic [3:0]        current_row;
		logic [6:0]        line_length;
		logic              scrolled;
	} op_t;

endpackage
`default_nettype wire

// File: rtl/tcs_front.sv
// Front end: accepts items, tracks cursor, ring offset and row lengths, emits ops.
`default_nettype none
module tcs_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	output logic             item_stall,
	input  tcs_pkg::in_item_t item,
	input  wire              q_full,
	output logic             push,
	output tcs_pkg::op_t     push_op
);
	import tcs_pkg::*;

	logic [ROW_W-1:0] cursor_q;
	logic [ROW_W-1:0] top_q;
	logic [LEN_W-1:0] cur_len_q;
	logic [LEN_W-1:0] len_q [SCREEN_ROWS];

	logic [ROW_W-1:0] cur_p, adv_p, rd_p, top_inc, n_cursor, n_top, len_idx;
	logic [LEN_W-1:0] n_len, rd_len;
	logic             at_last, is_wr, is_adv, len_wr, clr_all, scroll;

	function automatic logic [ROW_W-1:0] ring_add(input logic [ROW_W-1:0] a,
		input logic [ROW_W-1:0] b);
		logic [ROW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (ROW_W + 1)'(SCREEN_ROWS))
			s = s - (ROW_W + 1)'(SCREEN_ROWS);
		return s[ROW_W-1:0];
	endfunction

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;

	assign cur_p   = ring_add(top_q, cursor_q);
	assign at_last = (cursor_q == ROW_W'(SCREEN_ROWS - 1));
	assign top_inc = (top_q == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top_q + 1'b1;
	// Physical row below the cursor; after a scroll this is the old top row.
	assign adv_p   = (cur_p == ROW_W'(SCREEN_ROWS - 1)) ? '0 : cur_p + 1'b1;
	assign rd_p    = ring_add(top_q, item.row[ROW_W-1:0]);
	assign rd_len  = len_q[rd_p];

	assign is_wr  = (item.mode == MODE_WRITE) && (item.char_code != CH_NULL);
	assign is_adv = is_wr && ((item.char_code == CH_NEWLINE) ||
		((item.char_code != CH_BACKSPACE) && (cur_len_q == LEN_W'(SCREEN_COLS))));

	always_comb begin
		n_cursor = cursor_q;
		n_top    = top_q;
		n_len    = cur_len_q;
		len_idx  = cur_p;
		len_wr   = 1'b0;
		clr_all  = 1'b0;
		scroll   = 1'b0;
		push_op  = '0;
		push_op.addr = {cur_p, cur_len_q[COL_W-1:0]};
		push_op.wdata = item.char_code;
		if (is_adv) begin
			scroll   = at_last;
			n_cursor = at_last ? cursor_q : cursor_q + 1'b1;
			n_top    = at_last ? top_inc : top_q;
			len_idx  = adv_p;
			len_wr   = 1'b1;
			if (item.char_code == CH_NEWLINE) begin
				n_len = '0;
			end else begin
				n_len         = LEN_W'(1);
				push_op.wr_en = 1'b1;
				push_op.addr  = {adv_p, {COL_W{1'b0}}};
			end
		end else if (is_wr) begin
			len_wr = 1'b1;
			if (item.char_code == CH_BACKSPACE) begin
				if (cur_len_q != '0)
					n_len = cur_len_q - 1'b1;
			end else begin
				n_len         = cur_len_q + 1'b1;
				push_op.wr_en = 1'b1;
			end
		end else if (item.mode == MODE_READ) begin
			push_op.addr   = {rd_p, item.column[COL_W-1:0]};
			push_op.rd_hit = ({1'b0, item.row} < (ROW_W + 1)'(SCREEN_ROWS)) &&
				({1'b0, item.column} < rd_len) &&
				({1'b0, item.column} < LEN_W'(SCREEN_COLS));
		end else if (item.mode == MODE_CLEAR) begin
			clr_all  = 1'b1;
			n_cursor = '0;
			n_top    = '0;
			n_len    = '0;
		end
		push_op.current_row = n_cursor;
		push_op.line_length = n_len;
		push_op.scrolled    = scroll;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			top_q     <= '0;
			cur_len_q <= '0;
			for (int i = 0; i < SCREEN_ROWS; i++)
				len_q[i] <= '0;
		end else if (push) begin
			cursor_q  <= n_cursor;
			top_q     <= n_top;
			cur_len_q <= n_len;
			if (clr_all) begin
				for (int i = 0; i < SCREEN_ROWS; i++)
					len_q[i] <= '0;
			end else if (len_wr) begin
				len_q[len_idx] <= n_len;
			end
		end
	end

	ast_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= ROW_W'(SCREEN_ROWS - 1))
		else $error("cursor row out of range");

	ast_len_tracks_array: assert property (@(posedge clk) disable iff (!arst_n)
		cur_len_q == len_q[cur_p])
		else $error("cursor row length disagrees with row length table");

	ast_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_op.scrolled |=> cursor_q == ROW_W'(SCREEN_ROWS - 1))
		else $error("scroll left cursor off the bottom row");

endmodule
`default_nettype wire

// File: rtl/tcs_queue.sv
// Short op queue decoupling the front end from the cell store.
`default_nettype none
module tcs_queue (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  tcs_pkg::op_t push_op,
	output logic         full,
	input  wire          pop,
	output logic         not_empty,
	output tcs_pkg::op_t head
);
	import tcs_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: rtl/tcs_back.sv
// Back end: cell store access and result register.
`default_nettype none
module tcs_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               not_empty,
	input  tcs_pkg::op_t      head,
	output logic              pop,
	output logic              result_valid,
	input  wire               result_stall,
	output tcs_pkg::out_item_t result
);
	import tcs_pkg::*;

	logic [7:0]       cell_mem [SCREEN_ROWS * SCREEN_COLS];
	logic [7:0]       rd_data_q;
	logic             out_valid_q;
	logic             hit_q;
	logic [3:0]       row_q;
	logic [6:0]       len_q;
	logic             scrolled_q;

	// Advance whenever the result slot is empty or being taken.
	assign pop = not_empty && (!out_valid_q || !result_stall);

	always_ff @(posedge clk) begin
		if (pop && head.wr_en)
			cell_mem[head.addr] <= head.wdata;
		if (pop && head.rd_hit)
			rd_data_q <= cell_mem[head.addr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hit_q      <= head.rd_hit;
			row_q      <= head.current_row;
			len_q      <= head.line_length;
			scrolled_q <= head.scrolled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	assign result_valid = out_valid_q;
	assign result       = {(hit_q ? rd_data_q : 8'd0), row_q, len_q, scrolled_q};

endmodule
`default_nettype wire

// File: rtl/text_console_scroll_buffer.sv
// Text console scroll buffer: top level tying front end, op queue and cell store.
//
// Items arrive on item_valid/item/item_stall: mode 0 writes a character at the
// cursor (newline, backspace, row wrap and scroll handled), mode 1 reads a
// visible cell, mode 2 clears the screen. Every item yields exactly one result
// beat on result_valid/result/result_stall, in order.
// Throughput is one item per cycle while the op queue is not full: the front
// end updates cursor, ring offset and row lengths in the accept cycle, so
// scrolling is a pointer update. Accepted ops pass through the queue to the
// result register; the single-port cell store is accessed as ops leave the queue.
// When the receiver stalls, the result register holds; the 4-entry op queue
// keeps taking items until full, then item_stall rises.
// Reset clears cursor, ring offset, row lengths, the queue and result valid;
// cell contents are not cleared, as cells beyond a row's length read as 0.
`default_nettype none
module text_console_scroll_buffer (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_stall,
	input  tcs_pkg::in_item_t  item,
	output logic               result_valid,
	input  wire                result_stall,
	output tcs_pkg::out_item_t result
);
	import tcs_pkg::*;

	logic q_full, q_push, q_pop, q_not_empty;
	op_t  push_op, head_op;

	tcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (q_push),
		.push_op    (push_op)
	);

	tcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_op)
	);

	tcs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (q_not_empty),
		.head         (head_op),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

// File: bench/tcs_checker.sv
// Checker for the text console scroll buffer: predicts each result beat and compares it.
`timescale 1ns / 1ps
module tcs_checker (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	input  wire                item_stall,
	input  tcs_pkg::in_item_t  item,
	input  wire                result_valid,
	input  wire                result_stall,
	input  tcs_pkg::out_item_t result,
	output int                 errors,
	output int                 pending,
	output int                 checked,
	output int                 scrolls,
	output int                 read_hits
);
	import tcs_pkg::*;

	logic [7:0]       cells [SCREEN_ROWS][SCREEN_COLS];
	logic [6:0]       lens [SCREEN_ROWS];
	logic [ROW_W-1:0] cur_row;
	logic [ROW_W-1:0] top_row;
	out_item_t        expected_q[$];

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
		errors++;
	endtask

	// Move the cursor down; on the last row, recycle the top row as the new bottom row.
	task automatic cursor_down(output logic rolled);
		if (cur_row != ROW_W'(SCREEN_ROWS - 1)) begin
			cur_row = cur_row + 1'b1;
			rolled = 1'b0;
		end else begin
			lens[top_row] = '0;
			top_row = top_row + 1'b1;
			rolled = 1'b1;
		end
	endtask

	task automatic console_step(input in_item_t it, output out_item_t res);
		logic [ROW_W-1:0] p;
		logic             rolled;
		logic [7:0]       rd_char;
		rolled = 1'b0;
		rd_char = '0;
		p = top_row + cur_row;
		case (mode_t'(it.mode))
			MODE_WRITE: begin
				if (it.char_code == CH_NEWLINE) begin
					cursor_down(rolled);
				end else if (it.char_code == CH_BACKSPACE) begin
					if (lens[p] != 0)
						lens[p] = lens[p] - 1'b1;
				end else if (it.char_code != CH_NULL) begin
					if (lens[p] < SCREEN_COLS) begin
						cells[p][lens[p][COL_W-1:0]] = it.char_code;
						lens[p] = lens[p] + 1'b1;
					end else begin
						// Full row: wrap to column 0 of the next row.
						cursor_down(rolled);
						p = top_row + cur_row;
						cells[p][0] = it.char_code;
						lens[p] = 7'd1;
					end
				end
			end
			MODE_READ: begin
				p = top_row + it.row;
				if (it.column < lens[p])
					rd_char = cells[p][it.column];
			end
			MODE_CLEAR: begin
				for (int r = 0; r < SCREEN_ROWS; r++)
					lens[r] = '0;
				cur_row = '0;
				top_row = '0;
			end
			default: ;
		endcase
		p = top_row + cur_row;
		res.cell_char = rd_char;
		res.current_row = cur_row;
		res.line_length = lens[p];
		res.scrolled = rolled;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t pred;
		if (!arst_n) begin
			for (int r = 0; r < SCREEN_ROWS; r++) begin
				lens[r] = '0;
				for (int c = 0; c < SCREEN_COLS; c++)
					cells[r][c] = '0;
			end
			cur_row = '0;
			top_row = '0;
			expected_q.delete();
			pending = 0;
			errors = 0;
			checked = 0;
			scrolls = 0;
			read_hits = 0;
		end else begin
			// Retire the result beat first: it always belongs to an older item.
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result beat with nothing pending", 1, 0);
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (result.cell_char !== want.cell_char)
						report_mismatch("cell_char", int'(result.cell_char),
							int'(want.cell_char));
					if (result.current_row !== want.current_row)
						report_mismatch("current_row", int'(result.current_row),
							int'(want.current_row));
					if (result.line_length !== want.line_length)
						report_mismatch("line_length", int'(result.line_length),
							int'(want.line_length));
					if (result.scrolled !== want.scrolled)
						report_mismatch("scrolled", int'(result.scrolled),
							int'(want.scrolled));
					if (want.scrolled)
						scrolls++;
					if (want.cell_char != 0)
						read_hits++;
				end
			end
			if (item_valid && !item_stall) begin
				console_step(item, pred);
				expected_q.push_back(pred);
			end
			pending = expected_q.size();
		end
	end

endmodule

// File: bench/tb_top.sv
// Top of the text console scroll buffer bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import tcs_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	int idle_pct = 0;
	int stall_pct = 0;
	int sent = 0;
	int errors, pending, checked, scrolls, read_hits;

	always #6 clk = ~clk;

	always @(posedge clk)
		result_stall <= ($urandom_range(99) < stall_pct);

	text_console_scroll_buffer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	tcs_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.errors       (errors),
		.pending      (pending),
		.checked      (checked),
		.scrolls      (scrolls),
		.read_hits    (read_hits)
	);

	task automatic send(input in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		if (!(it.mode == MODE_NONE || (it.mode == MODE_WRITE && it.char_code == CH_NULL)))
			sent++;
	endtask

	task automatic put(input mode_t m, input logic [7:0] ch, input logic [3:0] r,
			input logic [5:0] c);
		in_item_t it;
		it.mode = m;
		it.char_code = ch;
		it.row = r;
		it.column = c;
		send(it);
	endtask

	// Hold off the sender until every pending beat has come back.
	task automatic drain();
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic random_burst();
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 45) begin
			// A line of text, sometimes long enough to overflow the row.
			n = ($urandom_range(3) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 8);
			repeat (n) begin
				if ($urandom_range(19) == 0)
					put(MODE_WRITE, CH_BACKSPACE, 4'($urandom), 6'($urandom));
				else
					put(MODE_WRITE, 8'($urandom_range(1, 255)), 4'($urandom), 6'($urandom));
			end
			if ($urandom_range(9) != 0)
				put(MODE_WRITE, CH_NEWLINE, 4'($urandom), 6'($urandom));
		end else if (kind < 75) begin
			repeat ($urandom_range(1, 4))
				put(MODE_READ, 8'($urandom), 4'($urandom_range(15)),
					6'($urandom_range(1) ? $urandom_range(7) : $urandom_range(63)));
		end else if (kind < 85) begin
			repeat ($urandom_range(1, 6))
				put(MODE_WRITE, CH_BACKSPACE, 4'($urandom), 6'($urandom));
		end else if (kind < 95) begin
			send(in_item_t'($urandom));
		end else if (kind < 96) begin
			put(MODE_CLEAR, 8'($urandom), 4'($urandom), 6'($urandom));
		end else begin
			put(MODE_NONE, 8'($urandom), 4'($urandom), 6'($urandom));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put(MODE_READ, 8'h00, 4'h0, 6'h00);
		put(MODE_NONE, 8'hFF, 4'hF, 6'h3F);
		put(MODE_WRITE, CH_NULL, 4'hF, 6'h3F);
		put(MODE_WRITE, CH_BACKSPACE, 4'h0, 6'h00);
		put(MODE_WRITE, 8'hFF, 4'h0, 6'h00);
		put(MODE_WRITE, 8'h01, 4'hF, 6'h3F);
		put(MODE_WRITE, 8'h41, 4'h0, 6'h00);
		put(MODE_READ, 8'hFF, 4'h0, 6'h00);
		put(MODE_READ, 8'h00, 4'h0, 6'h02);
		put(MODE_READ, 8'h00, 4'h0, 6'h03);
		put(MODE_READ, 8'h00, 4'hF, 6'h3F);
		put(MODE_WRITE, CH_BACKSPACE, 4'h0, 6'h00);
		put(MODE_READ, 8'h00, 4'h0, 6'h02);
		put(MODE_WRITE, CH_NEWLINE, 4'h0, 6'h00);
		put(MODE_WRITE, 8'h7E, 4'h0, 6'h00);
		put(MODE_READ, 8'h00, 4'h1, 6'h00);
		put(MODE_READ, 8'h00, 4'h0, 6'h01);
		put(MODE_CLEAR, 8'hFF, 4'hF, 6'h3F);
		put(MODE_READ, 8'h00, 4'h0, 6'h00);
		put(MODE_READ, 8'h00, 4'h1, 6'h00);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 81; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 81; end
				default: begin idle_pct = 10; stall_pct = 10; end
			endcase
			sent = 0;
			while (sent < 262)
				random_burst();
			drain();
		end

		stall_pct = 0;
		repeat (10) @(posedge clk);
		$display("Checked %0d result beats over four pacing phases.", checked);
		$display("The run saw %0d scrolls and %0d reads of stored characters.",
			scrolls, read_hits);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d beats still pending.", pending);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
